[hw/rtl/ucfp_pkg.sv]
// Package for the serial command frame parser.
// Holds the parse phase type, the frame byte codes and the field widths.
// No dependencies; the parser top level and the testbench use it by scoped names.
package ucfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int STORE_DEPTH = 8;
    localparam int SLOT_W  = 3;

    localparam logic [BYTE_W-1:0] PRE_V      = 8'h56;  // 'V'
    localparam logic [BYTE_W-1:0] PRE_Z      = 8'h5A;  // 'Z'
    localparam logic [BYTE_W-1:0] PRE_X      = 8'h58;  // 'X'
    localparam logic [BYTE_W-1:0] CMD_A      = 8'h41;  // 'A'
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] XOR_SEED   = 8'h55;
    localparam logic [BYTE_W-1:0] ADDR_RESET = 8'd76;  // 'L'

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_PRE2  = 3'd1,
        PH_ADDR  = 3'd2,
        PH_CMD   = 3'd3,
        PH_COUNT = 3'd4,
        PH_PARAM = 3'd5
    } phase_t;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

[hw/rtl/uart_command_frame_parser.sv]
// Serial command frame parser: top level, frame state machine and result register.
// Depends on ucfp_pkg.
//
// Usage
//   rx channel (rx_valid/rx_ready/rx_byte): one received byte per beat.
//   out channel (out_valid/out_ready/...): one result beat per completed frame,
//   carrying command, param_count, the eight parameter slots, side_select and
//   check_xor. A frame is 'V' or 'Z', 'X', board address, command, ASCII count
//   digit, then that many parameter bytes. Bad preamble, address or count drops
//   the frame and the parser hunts for a preamble again.
//   cfg_wr_en/cfg_wr_data write board_address; write it only while idle.
// Throughput and result timing
//   One byte per cycle while rx_ready is high. The byte that completes a frame shows
//   its result in the cycle after acceptance, through the result register.
// Reset
//   rst_n clears the phase, the counters, the parameter store, the XOR, the
//   side selection and the output valid; board_address returns to 76 ('L').
// Stall
//   While a result waits, bytes that cannot complete a frame are still taken.
//   Only a byte that could complete a frame is held off until out_ready.
module uart_command_frame_parser #(
    parameter int MAX_PARAMS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // byte input
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    // frame result
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] command,
    output logic [3:0] param_count,
    output logic [7:0] param_0,
    output logic [7:0] param_1,
    output logic [7:0] param_2,
    output logic [7:0] param_3,
    output logic [7:0] param_4,
    output logic [7:0] param_5,
    output logic [7:0] param_6,
    output logic [7:0] param_7,
    output logic [7:0] side_select,
    output logic [7:0] check_xor
);

    // parser state
    ucfp_pkg::phase_t phase_reg, phase_next;
    logic [ucfp_pkg::COUNT_W-1:0] remaining_reg, remaining_next;
    logic [ucfp_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    ucfp_pkg::byte_t command_reg, command_next;
    ucfp_pkg::byte_t store_reg [ucfp_pkg::STORE_DEPTH];
    ucfp_pkg::byte_t store_next [ucfp_pkg::STORE_DEPTH];
    logic [ucfp_pkg::COUNT_W-1:0] count_reg, count_next;
    ucfp_pkg::byte_t xor_reg, xor_next;
    ucfp_pkg::byte_t side_reg, side_next;
    ucfp_pkg::byte_t address_reg;

    // result register
    logic out_valid_reg, out_valid_next;
    ucfp_pkg::byte_t out_command_reg;
    logic [ucfp_pkg::COUNT_W-1:0] out_count_reg;
    ucfp_pkg::byte_t out_store_reg [ucfp_pkg::STORE_DEPTH];
    ucfp_pkg::byte_t out_side_reg;
    ucfp_pkg::byte_t out_xor_reg;

    logic rx_accept;
    logic emit;
    logic emit_possible;

    // A byte can only finish a frame as the count digit or the last parameter.
    assign emit_possible = (phase_reg == ucfp_pkg::PH_COUNT) ||
                           ((phase_reg == ucfp_pkg::PH_PARAM) &&
                            (remaining_reg == ucfp_pkg::COUNT_W'(1)));
    // Hold off only a byte that might need the result register while it is full.
    assign rx_ready  = !out_valid_reg || out_ready || !emit_possible;
    assign rx_accept = rx_valid && rx_ready;

    // Next-state logic: one step of the frame parser per accepted byte.
    always_comb
    begin
        ucfp_pkg::byte_t digit;
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        slot_next      = slot_reg;
        command_next   = command_reg;
        store_next     = store_reg;
        count_next     = count_reg;
        xor_next       = xor_reg;
        side_next      = side_reg;
        emit           = 1'b0;
        digit          = rx_byte - ucfp_pkg::ASCII_ZERO;
        if (rx_accept)
        begin
            case (phase_reg)
                ucfp_pkg::PH_HUNT:
                begin
                    if (rx_byte inside {ucfp_pkg::PRE_V, ucfp_pkg::PRE_Z})
                        phase_next = ucfp_pkg::PH_PRE2;
                end
                ucfp_pkg::PH_PRE2:
                begin
                    phase_next = (rx_byte == ucfp_pkg::PRE_X) ? ucfp_pkg::PH_ADDR
                                                              : ucfp_pkg::PH_HUNT;
                end
                ucfp_pkg::PH_ADDR:
                begin
                    phase_next = (rx_byte == address_reg) ? ucfp_pkg::PH_CMD
                                                          : ucfp_pkg::PH_HUNT;
                end
                ucfp_pkg::PH_CMD:
                begin
                    command_next = rx_byte;
                    xor_next     = ucfp_pkg::XOR_SEED ^ rx_byte;
                    phase_next   = ucfp_pkg::PH_COUNT;
                end
                ucfp_pkg::PH_COUNT:
                begin
                    if (digit > ucfp_pkg::BYTE_W'(MAX_PARAMS))
                    begin
                        // drop the frame on a bad count
                        phase_next = ucfp_pkg::PH_HUNT;
                    end
                    else
                    begin
                        xor_next   = xor_reg ^ rx_byte;
                        count_next = digit[ucfp_pkg::COUNT_W-1:0];
                        if (digit != '0)
                        begin
                            remaining_next = digit[ucfp_pkg::COUNT_W-1:0];
                            slot_next      = '0;
                            phase_next     = ucfp_pkg::PH_PARAM;
                        end
                        else
                        begin
                            phase_next = ucfp_pkg::PH_HUNT;
                            emit       = 1'b1;
                        end
                    end
                end
                ucfp_pkg::PH_PARAM:
                begin
                    store_next[slot_reg] = rx_byte;
                    xor_next       = xor_reg ^ rx_byte;
                    slot_next      = slot_reg + ucfp_pkg::SLOT_W'(1);
                    remaining_next = remaining_reg - ucfp_pkg::COUNT_W'(1);
                    if (remaining_reg == ucfp_pkg::COUNT_W'(1))
                    begin
                        if (command_reg != ucfp_pkg::CMD_A)
                            side_next = store_next[0] - ucfp_pkg::ASCII_ZERO;
                        phase_next = ucfp_pkg::PH_HUNT;
                        emit       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = ucfp_pkg::PH_HUNT;
                end
            endcase
        end

        // result valid: set on a completed frame, dropped when taken
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ucfp_pkg::PH_HUNT;
            remaining_reg <= '0;
            slot_reg      <= '0;
            command_reg   <= '0;
            store_reg     <= '{default: '0};
            count_reg     <= '0;
            xor_reg       <= '0;
            side_reg      <= '0;
            address_reg   <= ucfp_pkg::ADDR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            slot_reg      <= slot_next;
            command_reg   <= command_next;
            store_reg     <= store_next;
            count_reg     <= count_next;
            xor_reg       <= xor_next;
            side_reg      <= side_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                address_reg <= cfg_wr_data;
        end
    end

    // Capture a snapshot of the frame as it completes; hold it until taken.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_command_reg <= command_next;
            out_count_reg   <= count_next;
            out_store_reg   <= store_next;
            out_side_reg    <= side_next;
            out_xor_reg     <= xor_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign command     = out_command_reg;
    assign param_count = out_count_reg;
    assign param_0     = out_store_reg[0];
    assign param_1     = out_store_reg[1];
    assign param_2     = out_store_reg[2];
    assign param_3     = out_store_reg[3];
    assign param_4     = out_store_reg[4];
    assign param_5     = out_store_reg[5];
    assign param_6     = out_store_reg[6];
    assign param_7     = out_store_reg[7];
    assign side_select = out_side_reg;
    assign check_xor   = out_xor_reg;

endmodule

[hw/rtl/ucfp_checker.sv]
// Port-level checker for the serial command frame parser, with its bind.
// Depends only on the top level's ports.
module ucfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] command,
    input logic [3:0] param_count,
    input logic [7:0] param_0,
    input logic [7:0] param_1,
    input logic [7:0] param_2,
    input logic [7:0] param_3,
    input logic [7:0] param_4,
    input logic [7:0] param_5,
    input logic [7:0] param_6,
    input logic [7:0] param_7,
    input logic [7:0] check_xor
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its check value and command
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(check_xor) && $stable(command))
        else $error("result changed while stalled");

    // a new result only follows an accepted byte
    a_new_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rx_valid && rx_ready))
        else $error("result appeared without an input beat");

    // a full or empty frame: the XOR covers exactly the visible bytes
    a_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (param_count == 4'd8) |->
            check_xor == (8'h55 ^ command ^ 8'h38 ^ param_0 ^ param_1 ^ param_2 ^
                          param_3 ^ param_4 ^ param_5 ^ param_6 ^ param_7))
        else $error("check value wrong for full frame");

    a_xor_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (param_count == 4'd0) |-> check_xor == (8'h55 ^ command ^ 8'h30))
        else $error("check value wrong for empty frame");

endmodule

bind uart_command_frame_parser ucfp_checker u_ucfp_checker (.*);

[tb/sv/uart_command_frame_parser_tb.sv]
// Self-checking testbench for the serial command frame parser.
// Drives received bytes and takes frame results through valid/ready with random gaps.
// Depends on ucfp_pkg and uart_command_frame_parser; reads no files.
module uart_command_frame_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PARAMS    = 8;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;       // result register latency, with margin
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 6;
    localparam int FIXED_ADDRS   = 4;       // later phases draw a random address
    localparam int TRAFFIC_BYTES = 210;     // frame bytes per random phase
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int GAP_HEAVY     = 76;      // percent of cycles idle or stalled
    localparam int GAP_LIGHT     = 8;
    localparam int BROKEN_FROM   = 75;      // traffic mix thresholds, out of 100
    localparam int NOISE_FROM    = 90;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum logic [1:0] {FAULT_PRE2, FAULT_ADDR, FAULT_COUNT, FAULT_CUT} fault_t;

    // One completed frame as seen on the result port.
    typedef struct packed {
        ucfp_pkg::byte_t command;
        logic [3:0]      count;
        logic [7:0][7:0] params;
        ucfp_pkg::byte_t side;
        ucfp_pkg::byte_t chk;
    } frame_t;

    // One byte waiting to be offered, with an optional hand-written result.
    typedef struct packed {
        ucfp_pkg::byte_t b;
        logic            typed;
        frame_t          want;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] command;
    logic [3:0] param_count;
    logic [7:0] param_0, param_1, param_2, param_3;
    logic [7:0] param_4, param_5, param_6, param_7;
    logic [7:0] side_select;
    logic [7:0] check_xor;

    logic [7:0][7:0] out_params;
    assign out_params = {param_7, param_6, param_5, param_4,
                         param_3, param_2, param_1, param_0};

    uart_command_frame_parser #(
        .MAX_PARAMS(MAX_PARAMS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .command    (command),
        .param_count(param_count),
        .param_0    (param_0),
        .param_1    (param_1),
        .param_2    (param_2),
        .param_3    (param_3),
        .param_4    (param_4),
        .param_5    (param_5),
        .param_6    (param_6),
        .param_7    (param_7),
        .side_select(side_select),
        .check_xor  (check_xor)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the parser: state and board address, reset values.
    // ------------------------------------------------------------------
    ucfp_pkg::phase_t ph       = ucfp_pkg::PH_HUNT;
    ucfp_pkg::byte_t  addr_cfg = ucfp_pkg::ADDR_RESET;
    logic [3:0]       left     = 4'd0;
    logic [3:0]       slot     = 4'd0;
    logic [3:0]       cnt      = 4'd0;
    ucfp_pkg::byte_t  cmd_h    = 8'h00;
    logic [7:0][7:0]  store    = '0;
    ucfp_pkg::byte_t  xor_acc  = 8'h00;
    ucfp_pkg::byte_t  side_h   = 8'h00;

    beat_t      rx_backlog [$];   // bytes still to be offered
    frame_t     frames_due [$];   // results predicted but not yet seen
    beat_t      on_wire;          // the byte currently offered
    frame_t     due_frame;
    idle_mode_t idle_mode = IDLE_NONE;
    logic       hold_off = 1'b0;
    int         fail_count = 0;
    int         bytes_taken = 0;
    int         frames_checked = 0;
    int         cycle_count = 0;
    int         addr_writes = 0;

    // Advance the shadow parser by one accepted byte; flag a completed frame.
    task parse_byte(input ucfp_pkg::byte_t b, output logic done, output frame_t fr);
        ucfp_pkg::byte_t digit;
        done = 1'b0;
        fr = '0;
        case (ph)
            ucfp_pkg::PH_HUNT:
                if (b == ucfp_pkg::PRE_V || b == ucfp_pkg::PRE_Z)
                    ph = ucfp_pkg::PH_PRE2;
            ucfp_pkg::PH_PRE2:
                ph = (b == ucfp_pkg::PRE_X) ? ucfp_pkg::PH_ADDR : ucfp_pkg::PH_HUNT;
            ucfp_pkg::PH_ADDR:
                ph = (b == addr_cfg) ? ucfp_pkg::PH_CMD : ucfp_pkg::PH_HUNT;
            ucfp_pkg::PH_CMD:
            begin
                cmd_h = b;
                xor_acc = ucfp_pkg::XOR_SEED ^ b;
                ph = ucfp_pkg::PH_COUNT;
            end
            ucfp_pkg::PH_COUNT:
            begin
                // the digit wraps as a byte, so anything below '0' is huge too
                digit = b - ucfp_pkg::ASCII_ZERO;
                if (digit > MAX_PARAMS)
                    ph = ucfp_pkg::PH_HUNT;
                else
                begin
                    xor_acc = xor_acc ^ b;
                    cnt = digit[3:0];
                    if (digit != 8'h00)
                    begin
                        left = digit[3:0];
                        slot = 4'd0;
                        ph = ucfp_pkg::PH_PARAM;
                    end
                    else
                    begin
                        ph = ucfp_pkg::PH_HUNT;
                        done = 1'b1;
                    end
                end
            end
            ucfp_pkg::PH_PARAM:
            begin
                store[slot[2:0]] = b;
                xor_acc = xor_acc ^ b;
                slot = slot + 4'd1;
                left = left - 4'd1;
                if (left == 4'd0)
                begin
                    if (cmd_h != ucfp_pkg::CMD_A)
                        side_h = store[0] - ucfp_pkg::ASCII_ZERO;
                    ph = ucfp_pkg::PH_HUNT;
                    done = 1'b1;
                end
            end
            default:
                ph = ucfp_pkg::PH_HUNT;
        endcase
        if (done)
            fr = '{command: cmd_h, count: cnt, params: store, side: side_h, chk: xor_acc};
    endtask

    // ------------------------------------------------------------------
    // Byte sender. Predict on every accepted beat, then offer the next
    // byte unless a gap is drawn. Hold valid and data while not accepted.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic   made;
        frame_t fr;
        int     gap_pct;
        if (rst_n)
        begin
            if (rx_valid && rx_ready)
            begin
                parse_byte(on_wire.b, made, fr);
                if (made)
                    frames_due.push_back(on_wire.typed ? on_wire.want : fr);
                bytes_taken++;
            end
            gap_pct = (idle_mode == IDLE_SEND) ? GAP_HEAVY :
                      (idle_mode == IDLE_BOTH) ? GAP_LIGHT : 0;
            if (rx_valid && !rx_ready)
                ;   // hold the offered beat
            else if (rx_backlog.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                on_wire = rx_backlog.pop_front();
                rx_valid <= 1'b1;
                rx_byte <= on_wire.b;
            end
            else
                rx_valid <= 1'b0;
        end
    end

    task check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: frame %0d %s mismatch, expected %h, actual %h",
                     $realtime, frames_checked, what, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result receiver. Compare each accepted result with the oldest
    // prediction; draw the next stall unless a hold-off is running.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        int stall_pct;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $display("%0t: result with no frame expected, actual command %h count %h",
                             $realtime, command, param_count);
                    fail_count++;
                end
                else
                begin
                    due_frame = frames_due.pop_front();
                    check_field("command", due_frame.command, command);
                    check_field("param_count", {4'h0, due_frame.count}, {4'h0, param_count});
                    for (int k = 0; k < ucfp_pkg::STORE_DEPTH; k++)
                        check_field($sformatf("param_%0d", k), due_frame.params[k],
                                    out_params[k]);
                    check_field("side_select", due_frame.side, side_select);
                    check_field("check_xor", due_frame.chk, check_xor);
                end
                frames_checked++;
            end
            stall_pct = (idle_mode == IDLE_RECV) ? GAP_HEAVY :
                        (idle_mode == IDLE_BOTH) ? GAP_LIGHT : 0;
            out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: drop the run once the cycle count reaches CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d frames still due", cycle_count,
                     frames_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Opening bytes: a zero-count frame, a full frame of extremes, a bad
    // second preamble, a wrong address, a count digit that wraps below '0',
    // then an 'A' frame that must leave the side selection alone and report
    // the stale upper slots of the full frame.
    ucfp_pkg::byte_t opening_bytes [34] = '{
        ucfp_pkg::PRE_V, ucfp_pkg::PRE_X, ucfp_pkg::ADDR_RESET, 8'h00, ucfp_pkg::ASCII_ZERO,
        ucfp_pkg::PRE_Z, ucfp_pkg::PRE_X, ucfp_pkg::ADDR_RESET, 8'hFF, 8'h38,
        8'h30, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55,
        ucfp_pkg::PRE_V, 8'h51,
        ucfp_pkg::PRE_Z, ucfp_pkg::PRE_X, 8'h4D,
        ucfp_pkg::PRE_V, ucfp_pkg::PRE_X, ucfp_pkg::ADDR_RESET, ucfp_pkg::CMD_A, 8'h2F,
        ucfp_pkg::PRE_V, ucfp_pkg::PRE_X, ucfp_pkg::ADDR_RESET, ucfp_pkg::CMD_A, 8'h31, 8'h37
    };
    frame_t typed_frames [int];

    task offer(input ucfp_pkg::byte_t b);
        beat_t nb;
        nb.b = b;
        nb.typed = 1'b0;
        nb.want = '0;
        rx_backlog.push_back(nb);
    endtask

    // Queue random traffic: mostly well-formed frames for the current
    // address, some with one fault, and a little loose noise.
    task queue_traffic(input int budget);
        ucfp_pkg::byte_t fb [$];
        ucfp_pkg::byte_t b;
        int     taken;
        int     kind;
        int     nparam;
        int     cut_len;
        fault_t fault;
        taken = 0;
        while (taken < budget)
        begin
            kind = $urandom_range(99);
            fb.delete();
            if (kind >= NOISE_FROM)
            begin
                // loose bytes; the parser mostly ignores them, so do not count them
                repeat ($urandom_range(6, 1))
                    offer(ucfp_pkg::byte_t'($urandom_range(255)));
                continue;
            end
            fb.push_back($urandom_range(1) ? ucfp_pkg::PRE_V : ucfp_pkg::PRE_Z);
            fb.push_back(ucfp_pkg::PRE_X);
            fb.push_back(addr_cfg);
            fb.push_back(($urandom_range(3) == 0) ? ucfp_pkg::CMD_A
                                                  : ucfp_pkg::byte_t'($urandom_range(255)));
            nparam = $urandom_range(MAX_PARAMS);
            fb.push_back(ucfp_pkg::ASCII_ZERO + ucfp_pkg::byte_t'(nparam));
            // half the parameters are ASCII digits so the side selection stays readable
            repeat (nparam)
                fb.push_back($urandom_range(1)
                             ? ucfp_pkg::ASCII_ZERO + ucfp_pkg::byte_t'($urandom_range(9))
                             : ucfp_pkg::byte_t'($urandom_range(255)));
            if (kind >= BROKEN_FROM)
            begin
                fault = fault_t'($urandom_range(FAULT_CUT));
                case (fault)
                    FAULT_PRE2:
                    begin
                        do b = ucfp_pkg::byte_t'($urandom_range(255));
                        while (b == ucfp_pkg::PRE_X);
                        fb[1] = b;
                    end
                    FAULT_ADDR:
                    begin
                        do b = ucfp_pkg::byte_t'($urandom_range(255)); while (b == addr_cfg);
                        fb[2] = b;
                    end
                    FAULT_COUNT:
                    begin
                        do b = ucfp_pkg::byte_t'($urandom_range(255));
                        while (ucfp_pkg::byte_t'(b - ucfp_pkg::ASCII_ZERO) <= MAX_PARAMS);
                        fb[4] = b;
                    end
                    default:
                    begin
                        // truncate; the next frame runs into whatever phase is left
                        cut_len = $urandom_range(fb.size() - 1, 1);
                        while (fb.size() > cut_len)
                            void'(fb.pop_back());
                    end
                endcase
            end
            foreach (fb[i])
                offer(fb[i]);
            taken += fb.size();
        end
    endtask

    // Wait until every byte is taken and every result has arrived, then
    // let the result register settle before anything else is touched.
    task wait_idle();
        while (rx_backlog.size() != 0 || rx_valid || frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_address(input ucfp_pkg::byte_t value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        addr_cfg = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        addr_writes++;
    endtask

    idle_mode_t mode_plan [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV,
                                       IDLE_BOTH, IDLE_NONE, IDLE_SEND};
    // reset value, both extremes, and an address equal to a preamble byte
    ucfp_pkg::byte_t addr_plan [FIXED_ADDRS] = '{ucfp_pkg::ADDR_RESET, 8'h00, 8'hFF,
                                                 ucfp_pkg::PRE_V};

    initial
    begin
        beat_t nb;
        // zero count: XOR is the seed, the zero command and the digit '0'
        typed_frames[4] = '{command: 8'h00, count: 4'd0, params: '0,
                            side: 8'h00, chk: 8'h65};
        // full frame of extremes: first parameter '0' gives side select zero
        typed_frames[17] = '{command: 8'hFF, count: 4'd8,
                             params: 64'h55FE_017F_8000_FF30,
                             side: 8'h00, chk: 8'h08};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening at the reset address, no idling
        foreach (opening_bytes[i])
        begin
            nb.b = opening_bytes[i];
            nb.typed = typed_frames.exists(i);
            nb.want = nb.typed ? typed_frames[i] : '0;
            rx_backlog.push_back(nb);
        end
        wait_idle();

        // random phases, each with its own address and idling pattern
        for (int p = 0; p < PHASES; p++)
        begin
            write_address((p < FIXED_ADDRS) ? addr_plan[p]
                                            : ucfp_pkg::byte_t'($urandom_range(255)));
            idle_mode <= mode_plan[p];
            if (p == PRESSURE_PHASE)
            begin
                // stall the output for a long stretch while bytes keep coming,
                // so a finished result blocks the next completing byte
                hold_off <= 1'b1;
                fork
                    begin
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            queue_traffic(TRAFFIC_BYTES);
            wait_idle();
        end

        $display("Covered %0d received bytes and %0d checked frames over %0d address settings,",
                 bytes_taken, frames_checked, addr_writes);
        $display("with sender gaps, receiver stalls, both together and one long output hold-off.");
        if (fail_count == 0 && frames_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
